>>> rtl/row_mean_variance_assert.svh
// Assertion helpers for the row mean / variance block.
`ifndef ROW_MEAN_VARIANCE_ASSERT_SVH
`define ROW_MEAN_VARIANCE_ASSERT_SVH

// Same-cycle implication.
`define RMV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("row_mean_variance: assertion failed");

// Next-cycle implication.
`define RMV_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("row_mean_variance: assertion failed");

`endif

>>> rtl/rmv_pkg.sv
package rmv_pkg;

  localparam int CFG_W   = 13;   // row_length register
  localparam int MEAN_W  = 16;   // Q8.8 mean
  localparam int VAR_W   = 31;   // Q15.16 variance
  localparam int Q_DEPTH = 4;    // front-to-back row queue

  localparam logic signed [MEAN_W-1:0] MEAN_MAX = 16'sh7FFF;
  localparam logic signed [MEAN_W-1:0] MEAN_MIN = 16'sh8000;
  localparam logic [VAR_W-1:0]         VAR_MAX  = '1;

  // back-end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MEAN,
    BK_SQR,
    BK_OUT
  } rmv_bk_state_t;

  // queue status seen by front and back
  typedef struct packed {
    logic has_room;
    logic not_empty;
  } rmv_q_stat_t;

endpackage

>>> rtl/rmv_ifs.sv
interface rmv_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmv_pkg::MEAN_W-1:0]  row_mean;
  logic        [rmv_pkg::VAR_W-1:0]   row_variance;

  modport source (output valid, output row_mean, output row_variance, input ready);
  modport sink   (input valid, input row_mean, input row_variance, output ready);
endinterface

>>> rtl/row_mean_variance.sv
// Row mean and population variance. Samples (signed Q8.8, sign-extended from
// SAMPLE_WIDTH bits) arrive in row-major order; after row_length samples the
// block emits one item with the row mean (sum / m, truncated toward zero,
// saturated to 16 bits) and the population variance (floor(sumsq / m) minus
// mean squared, Q15.16, clamped to 0 .. 2^31-1). row_length of 0 acts as 1,
// values above MAX_ROW_LENGTH act as MAX_ROW_LENGTH; write it only while idle.
// The front takes one sample every cycle while the queue has room: a square
// register, then the accumulators. Finished rows go into a 4-entry queue. The
// back works one row at a time: it pops the queue, runs a bit-serial restoring
// divider, then registers mean, square and variance in turn. Rows at least as
// long as the back's time per row stream at one sample per cycle while results
// are taken; shorter rows run at the back's pace once the queue fills.
// No clearing pass after reset.
module row_mean_variance #(
  parameter int MAX_ROW_LENGTH = 4096,
  parameter int SAMPLE_WIDTH   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      row_length_we,
  input  logic [rmv_pkg::CFG_W-1:0] row_length_data,
  rmv_in_if.sink                    samples,
  rmv_out_if.source                 results
);
  import rmv_pkg::*;

  // count and accumulator widths follow the worst-case row
  localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);
  localparam int SUM_W = SAMPLE_WIDTH + LEN_W;
  localparam int SQ_W  = 2 * SAMPLE_WIDTH + LEN_W;
  localparam int QW    = SUM_W + SQ_W + LEN_W;

  rmv_q_stat_t             qstat;
  logic                    push;
  logic                    pop;
  logic signed [SUM_W-1:0] push_sum;
  logic [SQ_W-1:0]         push_sumsq;
  logic [LEN_W-1:0]        push_len;
  logic [QW-1:0]           q_wdata;
  logic [QW-1:0]           q_rdata;
  logic signed [SUM_W-1:0] row_sum;
  logic [SQ_W-1:0]         row_sumsq;
  logic [LEN_W-1:0]        row_len;

  // front: config register, squarer, accumulators, end-of-row detect
  rmv_front #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .LEN_W          (LEN_W),
    .SUM_W          (SUM_W),
    .SQ_W           (SQ_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .row_length_we   (row_length_we),
    .row_length_data (row_length_data),
    .samples         (samples),
    .qstat           (qstat),
    .push            (push),
    .push_sum        (push_sum),
    .push_sumsq      (push_sumsq),
    .push_len        (push_len)
  );

  // queue of finished row totals
  assign q_wdata = {push_sum, push_sumsq, push_len};

  rmv_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .stat  (qstat)
  );

  assign row_sum   = $signed(q_rdata[QW-1 -: SUM_W]);
  assign row_sumsq = q_rdata[LEN_W +: SQ_W];
  assign row_len   = q_rdata[LEN_W-1:0];

  // back: divide, saturate mean, square, subtract, output register
  rmv_back #(
    .LEN_W (LEN_W),
    .SUM_W (SUM_W),
    .SQ_W  (SQ_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .row_sum   (row_sum),
    .row_sumsq (row_sumsq),
    .row_len   (row_len),
    .pop       (pop),
    .results   (results)
  );

endmodule

>>> rtl/rmv_queue.sv
module rmv_queue #(
  parameter int W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [W-1:0]         wdata,
  input  logic                 pop,
  output logic [W-1:0]         rdata,
  output rmv_pkg::rmv_q_stat_t stat
);
  import rmv_pkg::*;

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [W-1:0]  mem [Q_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata = mem[rd_ptr];

  // one slot held back for the row still in the front pipeline
  assign stat.has_room  = (count < CW'(Q_DEPTH - 1));
  assign stat.not_empty = (count != '0);

endmodule

>>> rtl/rmv_front.sv
module rmv_front #(
  parameter int MAX_ROW_LENGTH = 4096,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int LEN_W          = 13,
  parameter int SUM_W          = 29,
  parameter int SQ_W           = 45
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          row_length_we,
  input  logic [rmv_pkg::CFG_W-1:0]     row_length_data,
  rmv_in_if.sink                        samples,
  input  rmv_pkg::rmv_q_stat_t          qstat,
  output logic                          push,
  output logic signed [SUM_W-1:0]       push_sum,
  output logic [SQ_W-1:0]               push_sumsq,
  output logic [LEN_W-1:0]              push_len
);
  import rmv_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  logic [CFG_W-1:0]      row_length;
  logic [LEN_W-1:0]      m_eff;
  logic [LEN_W-1:0]      count;
  logic [LEN_W:0]        count_inc;
  logic                  last;
  logic                  accept;
  logic signed [2*SW-1:0] prod;

  // square stage
  logic                  a_valid;
  logic                  a_last;
  logic signed [SW-1:0]  a_sample;
  logic [2*SW-1:0]       a_sq;
  logic [LEN_W-1:0]      a_len;

  // accumulators
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sumsq;
  logic signed [SUM_W-1:0] sum_next;
  logic [SQ_W-1:0]         sumsq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= CFG_W'(1);
    end else if (row_length_we) begin
      row_length <= row_length_data;
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (row_length == '0) begin
      m_eff = LEN_W'(1);
    end else if (CW'(row_length) > CW'(MAX_ROW_LENGTH)) begin
      m_eff = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      m_eff = LEN_W'(row_length);
    end
  end

  assign samples.ready = qstat.has_room;
  assign accept        = samples.valid && samples.ready;
  assign count_inc     = {1'b0, count} + 1'b1;
  assign last          = (count_inc >= {1'b0, m_eff});
  assign prod          = samples.sample * samples.sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        count <= last ? '0 : count_inc[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sample <= samples.sample;
      a_sq     <= $unsigned(prod);
      a_last   <= last;
      a_len    <= m_eff;
    end
  end

  assign sum_next   = sum + {{(SUM_W-SW){a_sample[SW-1]}}, a_sample};
  assign sumsq_next = sumsq + {{(SQ_W-2*SW){1'b0}}, a_sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      sumsq <= '0;
    end else if (a_valid) begin
      if (a_last) begin
        sum   <= '0;
        sumsq <= '0;
      end else begin
        sum   <= sum_next;
        sumsq <= sumsq_next;
      end
    end
  end

  assign push       = a_valid && a_last;
  assign push_sum   = sum_next;
  assign push_sumsq = sumsq_next;
  assign push_len   = a_len;

endmodule

>>> rtl/rmv_back.sv
module rmv_back #(
  parameter int LEN_W = 13,
  parameter int SUM_W = 29,
  parameter int SQ_W  = 45
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rmv_pkg::rmv_q_stat_t    qstat,
  input  logic signed [SUM_W-1:0] row_sum,
  input  logic [SQ_W-1:0]         row_sumsq,
  input  logic [LEN_W-1:0]        row_len,
  output logic                    pop,
  rmv_out_if.source               results
);
  import rmv_pkg::*;

  localparam int IW   = $clog2(SQ_W);
  localparam int WIDE = (SQ_W > 2*MEAN_W) ? SQ_W : 2*MEAN_W;

  rmv_bk_state_t state, state_next;

  logic div_step, mean_en, sq_en, out_load;

  logic                     neg;
  logic [SQ_W-1:0]          da;   // |sum| dividend, becomes quotient
  logic [SQ_W-1:0]          db;   // sumsq dividend, becomes quotient
  logic [LEN_W:0]           ra;
  logic [LEN_W:0]           rb;
  logic [LEN_W-1:0]         dm;
  logic [IW-1:0]            iter;
  logic signed [MEAN_W-1:0] mean;
  logic [2*MEAN_W-1:0]      msq;

  logic [SQ_W-1:0]          sum_ext;
  logic [LEN_W:0]           ra_sh, rb_sh;
  logic                     ge_a, ge_b;
  logic signed [MEAN_W-1:0] mean_sat;
  logic signed [2*MEAN_W-1:0] mean_prod;
  logic [WIDE-1:0]          qb_w, msq_w, diff;
  logic [VAR_W-1:0]         var_val;

  logic                     out_valid;
  logic signed [MEAN_W-1:0] out_mean;
  logic [VAR_W-1:0]         out_var;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (qstat.not_empty) state_next = BK_DIV;
      BK_DIV:  if (iter == '0) state_next = BK_MEAN;
      BK_MEAN: state_next = BK_SQR;
      BK_SQR:  state_next = BK_OUT;
      BK_OUT:  if (!out_valid || results.ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop      = 1'b0;
    div_step = 1'b0;
    mean_en  = 1'b0;
    sq_en    = 1'b0;
    out_load = 1'b0;
    case (state)
      BK_IDLE: pop = qstat.not_empty;
      BK_DIV:  div_step = 1'b1;
      BK_MEAN: mean_en = 1'b1;
      BK_SQR:  sq_en = 1'b1;
      BK_OUT:  out_load = !out_valid || results.ready;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // restoring division, one quotient bit per cycle for both dividends
  assign sum_ext = {{(SQ_W-SUM_W){row_sum[SUM_W-1]}}, row_sum};
  assign ra_sh   = {ra[LEN_W-1:0], da[SQ_W-1]};
  assign rb_sh   = {rb[LEN_W-1:0], db[SQ_W-1]};
  assign ge_a    = (ra_sh >= {1'b0, dm});
  assign ge_b    = (rb_sh >= {1'b0, dm});

  always_ff @(posedge clk) begin
    if (pop) begin
      neg  <= row_sum[SUM_W-1];
      da   <= row_sum[SUM_W-1] ? -sum_ext : sum_ext;
      db   <= row_sumsq;
      dm   <= row_len;
      ra   <= '0;
      rb   <= '0;
      iter <= IW'(SQ_W - 1);
    end else if (div_step) begin
      ra   <= ge_a ? ra_sh - {1'b0, dm} : ra_sh;
      rb   <= ge_b ? rb_sh - {1'b0, dm} : rb_sh;
      da   <= {da[SQ_W-2:0], ge_a};
      db   <= {db[SQ_W-2:0], ge_b};
      iter <= iter - 1'b1;
    end
  end

  // signed mean with saturation
  always_comb begin
    if (neg) begin
      if (da > SQ_W'(32768)) begin
        mean_sat = MEAN_MIN;
      end else begin
        mean_sat = -$signed(da[MEAN_W-1:0]);
      end
    end else begin
      if (da > SQ_W'(MEAN_MAX)) begin
        mean_sat = MEAN_MAX;
      end else begin
        mean_sat = $signed(da[MEAN_W-1:0]);
      end
    end
  end

  assign mean_prod = mean * mean;

  always_ff @(posedge clk) begin
    if (mean_en) begin
      mean <= mean_sat;
    end
    if (sq_en) begin
      msq <= $unsigned(mean_prod);
    end
  end

  // variance = sumsq/m - mean^2, clamped to [0, VAR_MAX]
  assign qb_w  = WIDE'(db);
  assign msq_w = WIDE'(msq);
  assign diff  = qb_w - msq_w;

  always_comb begin
    if (qb_w > msq_w) begin
      var_val = (diff > WIDE'(VAR_MAX)) ? VAR_MAX : diff[VAR_W-1:0];
    end else begin
      var_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean <= mean;
      out_var  <= var_val;
    end
  end

  assign results.valid        = out_valid;
  assign results.row_mean     = out_mean;
  assign results.row_variance = out_var;

endmodule

>>> rtl/rmv_checker.sv
`include "row_mean_variance_assert.svh"

module rmv_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_ready,
  input logic                              r_valid,
  input logic                              r_ready,
  input logic signed [rmv_pkg::MEAN_W-1:0] r_mean,
  input logic [rmv_pkg::VAR_W-1:0]         r_var
);

  // a stalled result stays, unchanged
  `RMV_ASSERT_NXT(a_hold_valid, clk, rst, r_valid && !r_ready, r_valid)
  `RMV_ASSERT_NXT(a_hold_data, clk, rst, r_valid && !r_ready, $stable(r_mean) && $stable(r_var))
  // reset empties the output register and the row queue
  `RMV_ASSERT_IMP(a_rst_out, clk, 1'b0, $past(rst), !r_valid)
  `RMV_ASSERT_NXT(a_rst_room, clk, 1'b0, rst, s_ready)

endmodule

bind row_mean_variance rmv_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .s_ready (samples.ready),
  .r_valid (results.valid),
  .r_ready (results.ready),
  .r_mean  (results.row_mean),
  .r_var   (results.row_variance)
);
